### rtl/i2c_register_access_master_top_macros.svh
// Assertion macros for the I2C register access master.
// Used by the RTL files that carry concurrent checks; needs signals clock and reset.
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH

// clocked check, off while reset is high
`define I2CRAM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// clocked check, also active during reset
`define I2CRAM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/i2cram_pkg.sv
// Package for the I2C register access master: phase codes, command codes,
// register indexes and the structs passed between modules. No dependencies.
`default_nettype none
package i2cram_pkg;

   typedef enum logic [3:0] {
      PH_IDLE         = 4'd0,
      PH_START_HIGH   = 4'd1,
      PH_START_LOW    = 4'd2,
      PH_RESTART_PREP = 4'd3,
      PH_TX_LOW       = 4'd4,
      PH_TX_HIGH      = 4'd5,
      PH_ACK_LOW      = 4'd6,
      PH_ACK_HIGH     = 4'd7,
      PH_ACK_POLL     = 4'd8,
      PH_RX_LOW       = 4'd9,
      PH_RX_HIGH      = 4'd10,
      PH_NACK_LOW     = 4'd11,
      PH_NACK_HIGH    = 4'd12,
      PH_STOP_LOW     = 4'd13,
      PH_STOP_HIGH    = 4'd14,
      PH_STOP_END     = 4'd15
   } phase_type;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] BS_ADDR = 2'd0;
   localparam logic [1:0] BS_REG  = 2'd1;
   localparam logic [1:0] BS_DATA = 2'd2;
   localparam logic [1:0] BS_RX   = 2'd3;

   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_HALF_PERIOD    = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT    = 2'd2;

   localparam logic       READ_BIT        = 1'b1;
   localparam logic [6:0] RST_DEVICE_ADDR = 7'd104;
   localparam logic [15:0] RST_HALF_PERIOD = 16'd5;
   localparam logic [7:0] RST_ACK_TIMEOUT = 8'd200;
   localparam logic [7:0] RST_READ_DATA   = 8'hFF;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] half_period;
      logic [7:0]  ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic       ack_error;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_pull_low;
      logic       scl_out;
   } result_type;

endpackage
`default_nettype wire

### rtl/i2cram_csr.sv
// Configuration registers of the I2C register access master.
// Depends on i2cram_pkg.
`default_nettype none
module i2cram_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_wdata,
   output i2cram_pkg::cfg_type  cfg
);
   import i2cram_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata[6:0];
            CSR_HALF_PERIOD:    cfg_in.half_period    = csr_wdata;
            CSR_ACK_TIMEOUT:    cfg_in.ack_timeout    = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= RST_DEVICE_ADDR;
         cfg_ff.half_period    <= RST_HALF_PERIOD;
         cfg_ff.ack_timeout    <= RST_ACK_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### rtl/i2cram_seq.sv
// Bit-level bus sequencer: advances one tick per accepted transaction and
// computes the line levels and status for that tick. Depends on i2cram_pkg.
`default_nettype none
module i2cram_seq #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic [1:0]         operation,
   input  wire logic [7:0]         reg_address,
   input  wire logic [7:0]         write_data,
   input  wire logic               sda_in,
   input  wire i2cram_pkg::cfg_type cfg,
   output i2cram_pkg::result_type  result
);
   import i2cram_pkg::*;

   localparam int CW = (TIMER_BITS + 1 > 16) ? TIMER_BITS + 1 : 16;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in, timer_adv;
   logic [TIMER_BITS:0]   timer_nx;
   logic                  half_done;
   logic [2:0]            bit_ff, bit_in;
   logic [3:0]            bit_nx;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            rx_ff, rx_in;
   logic [7:0]            wait_ff, wait_in;
   logic [8:0]            wait_nx;
   logic                  is_read_ff, is_read_in;
   logic                  err_ff, err_in;
   logic [1:0]            step_ff, step_in;
   logic [7:0]            lreg_ff, lreg_in;
   logic [7:0]            ldata_ff, ldata_in;
   logic                  done;

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      rx_in      = rx_ff;
      wait_in    = wait_ff;
      is_read_in = is_read_ff;
      err_in     = err_ff;
      step_in    = step_ff;
      lreg_in    = lreg_ff;
      ldata_in   = ldata_ff;
      done       = 1'b0;

      timer_nx  = {1'b0, timer_ff} + {{TIMER_BITS{1'b0}}, 1'b1};
      half_done = (CW'(timer_nx) >= CW'(cfg.half_period)) || timer_nx[TIMER_BITS];
      timer_adv = half_done ? '0 : timer_nx[TIMER_BITS-1:0];
      bit_nx    = {1'b0, bit_ff} + 4'd1;
      wait_nx   = {1'b0, wait_ff} + 9'd1;

      unique case (phase_ff)
         PH_IDLE: begin
            if (operation == OP_WRITE || operation == OP_READ) begin
               is_read_in = (operation == OP_READ);
               lreg_in    = reg_address;
               ldata_in   = write_data;
               err_in     = 1'b0;
               step_in    = BS_ADDR;
               bit_in     = '0;
               wait_in    = '0;
               timer_in   = '0;
               phase_in   = PH_START_HIGH;
            end
         end
         PH_START_HIGH: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_START_LOW;
         end
         PH_START_LOW: begin
            timer_in = timer_adv;
            if (half_done) begin
               shift_in = (step_ff == BS_ADDR) ? {cfg.device_address, 1'b0}
                                               : {cfg.device_address, READ_BIT};
               bit_in   = '0;
               phase_in = PH_TX_LOW;
            end
         end
         PH_RESTART_PREP: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_START_HIGH;
         end
         PH_TX_LOW: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_TX_HIGH;
         end
         PH_TX_HIGH: begin
            timer_in = timer_adv;
            if (half_done) begin
               shift_in = {shift_ff[6:0], 1'b0};
               if (bit_nx[3]) begin
                  bit_in   = '0;
                  phase_in = PH_ACK_LOW;
               end else begin
                  bit_in   = bit_nx[2:0];
                  phase_in = PH_TX_LOW;
               end
            end
         end
         PH_ACK_LOW: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            timer_in = timer_adv;
            if (half_done) begin
               wait_in  = '0;
               phase_in = PH_ACK_POLL;
            end
         end
         PH_ACK_POLL: begin
            timer_in = '0;
            if (!sda_in) begin
               wait_in = '0;
               case (step_ff)
                  BS_ADDR: begin
                     step_in  = BS_REG;
                     shift_in = lreg_ff;
                     bit_in   = '0;
                     phase_in = PH_TX_LOW;
                  end
                  BS_REG: begin
                     step_in = BS_DATA;
                     if (is_read_ff) begin
                        phase_in = PH_RESTART_PREP;
                     end else begin
                        shift_in = ldata_ff;
                        bit_in   = '0;
                        phase_in = PH_TX_LOW;
                     end
                  end
                  BS_DATA: begin
                     if (is_read_ff) begin
                        step_in  = BS_RX;
                        shift_in = '0;
                        bit_in   = '0;
                        phase_in = PH_RX_LOW;
                     end else begin
                        phase_in = PH_STOP_LOW;
                     end
                  end
                  default: phase_in = PH_STOP_LOW;
               endcase
            end else if (wait_nx >= {1'b0, cfg.ack_timeout}) begin
               wait_in  = '0;
               err_in   = 1'b1;
               phase_in = PH_STOP_LOW;
            end else begin
               wait_in = wait_nx[7:0];
            end
         end
         PH_RX_LOW: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_RX_HIGH;
         end
         PH_RX_HIGH: begin
            timer_in = timer_adv;
            if (half_done) begin
               shift_in = {shift_ff[6:0], sda_in};
               if (bit_nx[3]) begin
                  bit_in   = '0;
                  rx_in    = {shift_ff[6:0], sda_in};
                  phase_in = PH_NACK_LOW;
               end else begin
                  bit_in   = bit_nx[2:0];
                  phase_in = PH_RX_LOW;
               end
            end
         end
         PH_NACK_LOW: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_NACK_HIGH;
         end
         PH_NACK_HIGH: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_STOP_LOW;
         end
         PH_STOP_LOW: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_STOP_HIGH;
         end
         PH_STOP_HIGH: begin
            timer_in = timer_adv;
            if (half_done) phase_in = PH_STOP_END;
         end
         PH_STOP_END: begin
            timer_in = timer_adv;
            if (half_done) begin
               done     = 1'b1;
               step_in  = BS_ADDR;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            timer_in = '0;
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      result.scl_out      = 1'b1;
      result.sda_pull_low = 1'b0;
      case (phase_in)
         PH_START_LOW: begin
            result.scl_out      = 1'b1;
            result.sda_pull_low = 1'b1;
         end
         PH_RESTART_PREP, PH_ACK_LOW, PH_RX_LOW, PH_NACK_LOW: begin
            result.scl_out      = 1'b0;
            result.sda_pull_low = 1'b0;
         end
         PH_TX_LOW: begin
            result.scl_out      = 1'b0;
            result.sda_pull_low = !shift_in[7];
         end
         PH_TX_HIGH: begin
            result.scl_out      = 1'b1;
            result.sda_pull_low = !shift_in[7];
         end
         PH_STOP_LOW: begin
            result.scl_out      = 1'b0;
            result.sda_pull_low = 1'b1;
         end
         PH_STOP_HIGH: begin
            result.scl_out      = 1'b1;
            result.sda_pull_low = 1'b1;
         end
         default: begin
            result.scl_out      = 1'b1;
            result.sda_pull_low = 1'b0;
         end
      endcase
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.read_data = rx_in;
      result.ack_error = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         rx_ff      <= RST_READ_DATA;
         wait_ff    <= '0;
         is_read_ff <= 1'b0;
         err_ff     <= 1'b0;
         step_ff    <= BS_ADDR;
         lreg_ff    <= '0;
         ldata_ff   <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         rx_ff      <= rx_in;
         wait_ff    <= wait_in;
         is_read_ff <= is_read_in;
         err_ff     <= err_in;
         step_ff    <= step_in;
         lreg_ff    <= lreg_in;
         ldata_ff   <= ldata_in;
      end
   end

endmodule
`default_nettype wire

### rtl/i2cram_out.sv
// Result register of the I2C register access master: holds one transaction
// until the receiver takes it. Depends on i2cram_pkg.
`default_nettype none
module i2cram_out (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire i2cram_pkg::result_type result,
   output logic                        space,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output i2cram_pkg::result_type      rsp_result
);
   import i2cram_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

endmodule
`default_nettype wire

### rtl/i2c_register_access_master_top.sv
// Top level of the single-byte I2C register access master.
// Depends on i2cram_pkg, i2cram_csr, i2cram_seq, i2cram_out and the macro header.
//
// Every req transaction is one timebase tick. On a tick in idle, a write (1)
// or read (2) command starts a bus transfer; other codes, and commands while
// busy, just advance time. Each req transaction yields exactly one rsp
// transaction carrying the bus line levels, busy, done, the last read byte
// and the error flag after that tick.
// The registered rsp transaction is valid in the cycle after req acceptance.
// Throughput: one tick per cycle when not stalled; the sequencer updates in
// the accepting cycle; the single result register is reloaded while drained.
// Stall: when rsp_tready is low and a result is held, req_tready drops and
// the sequencer holds its state; no tick is lost or repeated.
// Reset (synchronous): idle, lines released, read byte all ones, registers at
// device address 104, half period 5 ticks, acknowledge timeout 200 samples.
// csr writes are taken at any edge with csr_we high; write them while idle.
`default_nettype none
`include "i2c_register_access_master_top_macros.svh"
module i2c_register_access_master_top #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // reg_address[7:0], write_data[15:8], sda_in[16]
   input  wire logic [1:0]  req_tuser,   // operation[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // scl_out[0], sda_pull_low[1], busy_res[2],
                                         // done_res[3], read_data[11:4], ack_error[12]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import i2cram_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_result;
   logic       space;
   logic       accept;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   i2cram_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cram_seq #(
      .TIMER_BITS (TIMER_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .operation   (req_tuser),
      .reg_address (req_tdata[7:0]),
      .write_data  (req_tdata[15:8]),
      .sda_in      (req_tdata[16]),
      .cfg         (cfg),
      .result      (result)
   );

   i2cram_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {3'b000, rsp_result.ack_error, rsp_result.read_data,
                       rsp_result.done_res, rsp_result.busy_res,
                       rsp_result.sda_pull_low, rsp_result.scl_out};

   `I2CRAM_ASSERT(a_done_not_busy,
      rsp_tvalid && rsp_result.done_res |-> !rsp_result.busy_res,
      "done reported while busy")
   `I2CRAM_ASSERT(a_idle_released,
      rsp_tvalid && !rsp_result.busy_res |-> rsp_result.scl_out && !rsp_result.sda_pull_low,
      "lines not released in idle")
   `I2CRAM_ASSERT(a_accept_yields_rsp, req_tvalid && req_tready |=> rsp_tvalid,
      "accepted tick produced no result")
   `I2CRAM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result pending after reset")

endmodule
`default_nettype wire
